// ===== rtl/core/cbfq_pkg.sv =====
package cbfq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;

   localparam int REQ_TDATA_W  = 184;
   localparam int RSP_TDATA_W  = 152;
   localparam int HANDLE_W     = 16;
   localparam int PIXEL_W      = 16;
   localparam int STRIDE_W     = 18;
   localparam int SIZE_W       = 34;
   localparam int GEN_W        = 32;
   localparam int DIAG_W       = 16;
   localparam int FRAMES_W     = 5;
   localparam int BYTES_W      = 40;
   localparam int CSR_INDEX_W  = 1;

   localparam logic [FRAMES_W-1:0] MAX_FRAMES_RESET = 5'd16;
   localparam logic [BYTES_W-1:0]  MAX_BYTES_RESET  = 40'hFF_FFFF_FFFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_FRAMES = 1'b0,
      CSR_MAX_BYTES  = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      REQ_PUBLISH = 3'd0,
      REQ_TAKE    = 3'd1,
      REQ_DRAIN   = 3'd2,
      REQ_CANCEL  = 3'd3,
      REQ_FAIL    = 3'd4,
      REQ_RELEASE = 3'd5
   } req_code_type;

   typedef enum logic [3:0] {
      ST_ACCEPTED    = 4'd0,
      ST_INVALID     = 4'd1,
      ST_CLOSED      = 4'd2,
      ST_CANCELLED   = 4'd3,
      ST_FAILED      = 4'd4,
      ST_WOULD_BLOCK = 4'd5,
      ST_FRAME       = 4'd6,
      ST_EMPTY       = 4'd7,
      ST_ENDED       = 4'd8,
      ST_DONE        = 4'd9
   } status_type;

   typedef enum logic [2:0] {
      MODE_OPEN      = 3'd0,
      MODE_DRAINING  = 3'd1,
      MODE_ENDED     = 3'd2,
      MODE_CANCELLED = 3'd3,
      MODE_FAILED    = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      FSM_IDLE   = 2'd0,
      FSM_MUL    = 2'd1,
      FSM_COMMIT = 2'd2
   } fsm_state_type;

   typedef struct packed {
      logic load_req;
      logic load_prod;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

// ===== rtl/core/credit_bounded_frame_queue_unit.sv =====
// rsp_tvalid rises when the result register is loaded by the commit in FSM_COMMIT,
// after FSM_MUL; one request is handled at a time (accept, stride-times-height multiply,
//   commit with the registered descriptor-store read), and an output stall holds the commit.
// Reset (synchronous, active high): queue open, credits, pointers and counts zero,
//   limits at their defaults, no transaction taken; descriptor store not cleared.
module credit_bounded_frame_queue_unit #(
   parameter int QUEUE_DEPTH = cbfq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // frame handle, pixel width, pixel height, row stride, byte count, buffer size,
   // format flag, fail generation, fail diag, diag flag
   input  logic [cbfq_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // req_type
   input  logic [2:0]                        req_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cbfq_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cbfq_pkg::BYTES_W-1:0]      csr_data,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_handle, out_bytes, out_fail_generation, out_fail_diag, queue_mode,
   // frames_outstanding, bytes_outstanding, zero pad
   output logic [cbfq_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // status
   output logic [3:0]                        rsp_tuser
);

   cbfq_pkg::ctrl_cmd_type  cmd;
   cbfq_pkg::dp_status_type dp_status;

   assign csr_ready = !reset;

   cbfq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_status  (dp_status),
      .cmd        (cmd)
   );

   cbfq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .dp_status  (dp_status)
   );

   a_commit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_tvalid || rsp_tready))
      else $error("commit while result register is still occupied");

   a_commit_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("committed result not presented");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second request accepted while one is in flight");

   a_commit_after_multiply: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> ($past(cmd.load_prod) || $past(cmd.commit) == 1'b0))
      else $error("commit without a preceding multiply");

endmodule

// ===== rtl/core/cbfq_ctrl.sv =====
module cbfq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  cbfq_pkg::dp_status_type dp_status,
   output cbfq_pkg::ctrl_cmd_type  cmd
);

   cbfq_pkg::fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cbfq_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cbfq_pkg::FSM_IDLE: begin
            if (req_tvalid) state_in = cbfq_pkg::FSM_MUL;
         end
         cbfq_pkg::FSM_MUL: begin
            state_in = cbfq_pkg::FSM_COMMIT;
         end
         cbfq_pkg::FSM_COMMIT: begin
            if (dp_status.out_free) state_in = cbfq_pkg::FSM_IDLE;
         end
         default: begin
            state_in = cbfq_pkg::FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      cmd.load_req  = 1'b0;
      cmd.load_prod = 1'b0;
      cmd.commit    = 1'b0;
      unique case (state_ff)
         cbfq_pkg::FSM_IDLE: begin
            req_tready   = !reset;
            cmd.load_req = req_tvalid && !reset;
         end
         cbfq_pkg::FSM_MUL: begin
            cmd.load_prod = 1'b1;
         end
         cbfq_pkg::FSM_COMMIT: begin
            cmd.commit = dp_status.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/core/cbfq_datapath.sv =====
module cbfq_datapath #(
   parameter int QUEUE_DEPTH = cbfq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [cbfq_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic [2:0]                          req_tuser,
   input  logic                                csr_valid,
   input  logic [cbfq_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cbfq_pkg::BYTES_W-1:0]        csr_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [cbfq_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic [3:0]                          rsp_tuser,
   input  cbfq_pkg::ctrl_cmd_type              cmd,
   output cbfq_pkg::dp_status_type             dp_status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int QB_W  = cbfq_pkg::SIZE_W + CNT_W;
   localparam int CMP_W = (QB_W > cbfq_pkg::BYTES_W) ? QB_W : cbfq_pkg::BYTES_W;
   localparam int HW    = cbfq_pkg::HANDLE_W;
   localparam int SW    = cbfq_pkg::SIZE_W;
   localparam int BW    = cbfq_pkg::BYTES_W;
   localparam int FW    = cbfq_pkg::FRAMES_W;
   localparam int GW    = cbfq_pkg::GEN_W;
   localparam int DW    = cbfq_pkg::DIAG_W;

   // configuration
   logic [FW-1:0] max_frames_ff;
   logic [BW-1:0] max_bytes_ff;

   // latched request
   cbfq_pkg::req_code_type        req_type_ff;
   logic [HW-1:0]                 handle_ff;
   logic [cbfq_pkg::PIXEL_W-1:0]  width_ff, height_ff;
   logic [cbfq_pkg::STRIDE_W-1:0] stride_ff;
   logic [SW-1:0]                 vbytes_ff, buf_ff;
   logic                          format_ok_ff, diag_ok_ff;
   logic [GW-1:0]                 gen_ff;
   logic [DW-1:0]                 diag_ff;
   logic [SW-1:0]                 prod_ff;

   // queue state
   cbfq_pkg::mode_type mode_ff, mode_in;
   logic [FW-1:0]      frame_ff, frame_in;
   logic [BW-1:0]      used_ff, used_in;
   logic [QB_W-1:0]    qbytes_ff, qbytes_in;
   logic [CNT_W-1:0]   queued_ff, queued_in;
   logic [PTR_W-1:0]   rptr_ff, rptr_in, wptr_ff, wptr_in;
   logic [GW-1:0]      sgen_ff, sgen_in;
   logic [DW-1:0]      sdiag_ff, sdiag_in;

   // descriptor store
   logic [HW-1:0] handle_mem [QUEUE_DEPTH];
   logic [SW-1:0] size_mem [QUEUE_DEPTH];
   logic [HW-1:0] rd_handle_ff;
   logic [SW-1:0] rd_size_ff;
   logic          mem_we;

   // result register
   logic                 rsp_valid_ff;
   cbfq_pkg::status_type status_ff, status_c;
   logic [HW-1:0]        oh_ff, oh_c;
   logic [SW-1:0]        ob_ff, ob_c;
   logic [GW-1:0]        og_ff, og_c;
   logic [DW-1:0]        od_ff, od_c;

   logic shape_bad, frames_full, bytes_full;
   logic [FW-1:0] drop_frame;
   logic [BW-1:0] drop_bytes;
   logic [BW-1:0] rel_bytes;
   logic [PTR_W-1:0] rptr_next, wptr_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frames_ff <= cbfq_pkg::MAX_FRAMES_RESET;
         max_bytes_ff  <= cbfq_pkg::MAX_BYTES_RESET;
      end else if (csr_valid) begin
         unique case (cbfq_pkg::csr_index_type'(csr_index))
            cbfq_pkg::CSR_MAX_FRAMES: max_frames_ff <= csr_data[FW-1:0];
            cbfq_pkg::CSR_MAX_BYTES:  max_bytes_ff  <= csr_data;
            default: max_bytes_ff <= max_bytes_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_type_ff  <= cbfq_pkg::req_code_type'(req_tuser);
         handle_ff    <= req_tdata[15:0];
         width_ff     <= req_tdata[31:16];
         height_ff    <= req_tdata[47:32];
         stride_ff    <= req_tdata[65:48];
         vbytes_ff    <= req_tdata[99:66];
         buf_ff       <= req_tdata[133:100];
         format_ok_ff <= req_tdata[134];
         gen_ff       <= req_tdata[166:135];
         diag_ff      <= req_tdata[182:167];
         diag_ok_ff   <= req_tdata[183];
      end
      if (cmd.load_prod) begin
         prod_ff <= SW'(stride_ff) * SW'(height_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         handle_mem[wptr_ff] <= handle_ff;
         size_mem[wptr_ff]   <= vbytes_ff;
      end
      rd_handle_ff <= handle_mem[rptr_ff];
      rd_size_ff   <= size_mem[rptr_ff];
   end

   assign rptr_next = (rptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
   assign wptr_next = (wptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
   assign rel_bytes = BW'(vbytes_ff);

   always_comb begin
      shape_bad = (width_ff == '0) || (height_ff == '0) || (buf_ff == '0)
                  || (stride_ff < {width_ff, 2'b00}) || (vbytes_ff != prod_ff)
                  || (vbytes_ff > buf_ff) || !format_ok_ff
                  || (max_frames_ff == '0) || (max_bytes_ff == '0);
      frames_full = (frame_ff >= max_frames_ff)
                    || (32'(frame_ff) >= 32'(QUEUE_DEPTH))
                    || (queued_ff == CNT_W'(QUEUE_DEPTH));
      bytes_full  = ((BW+1)'(used_ff) + (BW+1)'(vbytes_ff)) > (BW+1)'(max_bytes_ff);
      drop_frame  = (32'(queued_ff) > 32'(frame_ff)) ? '0 : frame_ff - FW'(queued_ff);
      drop_bytes  = (CMP_W'(qbytes_ff) > CMP_W'(used_ff)) ? '0
                    : used_ff - BW'(qbytes_ff);
   end

   always_comb begin
      mode_in   = mode_ff;
      frame_in  = frame_ff;
      used_in   = used_ff;
      qbytes_in = qbytes_ff;
      queued_in = queued_ff;
      rptr_in   = rptr_ff;
      wptr_in   = wptr_ff;
      sgen_in   = sgen_ff;
      sdiag_in  = sdiag_ff;
      mem_we    = 1'b0;
      status_c  = cbfq_pkg::ST_INVALID;
      oh_c      = '0;
      ob_c      = '0;
      og_c      = '0;
      od_c      = '0;
      case (req_type_ff)
         cbfq_pkg::REQ_PUBLISH: begin
            if (shape_bad) begin
               status_c = cbfq_pkg::ST_INVALID;
            end else begin
               case (mode_ff) inside
                  cbfq_pkg::MODE_OPEN: begin
                     if (frames_full || bytes_full) begin
                        status_c = cbfq_pkg::ST_WOULD_BLOCK;
                     end else begin
                        status_c  = cbfq_pkg::ST_ACCEPTED;
                        mem_we    = cmd.commit;
                        wptr_in   = wptr_next;
                        queued_in = queued_ff + 1'b1;
                        frame_in  = frame_ff + 1'b1;
                        used_in   = used_ff + BW'(vbytes_ff);
                        qbytes_in = qbytes_ff + QB_W'(vbytes_ff);
                     end
                  end
                  cbfq_pkg::MODE_DRAINING, cbfq_pkg::MODE_ENDED:
                     status_c = cbfq_pkg::ST_CLOSED;
                  cbfq_pkg::MODE_CANCELLED:
                     status_c = cbfq_pkg::ST_CANCELLED;
                  default:
                     status_c = cbfq_pkg::ST_FAILED;
               endcase
            end
         end
         cbfq_pkg::REQ_TAKE: begin
            if (queued_ff != '0) begin
               status_c  = cbfq_pkg::ST_FRAME;
               oh_c      = rd_handle_ff;
               ob_c      = rd_size_ff;
               rptr_in   = rptr_next;
               queued_in = queued_ff - 1'b1;
               qbytes_in = qbytes_ff - QB_W'(rd_size_ff);
            end else begin
               case (mode_ff) inside
                  cbfq_pkg::MODE_OPEN, cbfq_pkg::MODE_DRAINING:
                     status_c = cbfq_pkg::ST_EMPTY;
                  cbfq_pkg::MODE_ENDED:
                     status_c = cbfq_pkg::ST_ENDED;
                  cbfq_pkg::MODE_CANCELLED:
                     status_c = cbfq_pkg::ST_CANCELLED;
                  default: begin
                     status_c = cbfq_pkg::ST_FAILED;
                     og_c     = sgen_ff;
                     od_c     = sdiag_ff;
                  end
               endcase
            end
         end
         cbfq_pkg::REQ_DRAIN: begin
            status_c = cbfq_pkg::ST_DONE;
            if (mode_ff == cbfq_pkg::MODE_OPEN) begin
               mode_in = (frame_ff == '0) ? cbfq_pkg::MODE_ENDED : cbfq_pkg::MODE_DRAINING;
            end
         end
         cbfq_pkg::REQ_CANCEL: begin
            status_c = cbfq_pkg::ST_DONE;
            if (mode_ff == cbfq_pkg::MODE_OPEN || mode_ff == cbfq_pkg::MODE_DRAINING) begin
               mode_in   = cbfq_pkg::MODE_CANCELLED;
               frame_in  = drop_frame;
               used_in   = drop_bytes;
               qbytes_in = '0;
               queued_in = '0;
               wptr_in   = rptr_ff;
            end
         end
         cbfq_pkg::REQ_FAIL: begin
            status_c = cbfq_pkg::ST_DONE;
            if ((mode_ff == cbfq_pkg::MODE_OPEN || mode_ff == cbfq_pkg::MODE_DRAINING)
                && (gen_ff != '0) && diag_ok_ff) begin
               mode_in   = cbfq_pkg::MODE_FAILED;
               sgen_in   = gen_ff;
               sdiag_in  = diag_ff;
               frame_in  = drop_frame;
               used_in   = drop_bytes;
               qbytes_in = '0;
               queued_in = '0;
               wptr_in   = rptr_ff;
            end
         end
         cbfq_pkg::REQ_RELEASE: begin
            if ((frame_ff == '0) || (rel_bytes > used_ff)) begin
               status_c = cbfq_pkg::ST_INVALID;
            end else begin
               status_c = cbfq_pkg::ST_ACCEPTED;
               frame_in = frame_ff - 1'b1;
               used_in  = used_ff - rel_bytes;
               if (mode_ff == cbfq_pkg::MODE_DRAINING && frame_ff == FW'(1)) begin
                  mode_in = cbfq_pkg::MODE_ENDED;
               end
            end
         end
         default: begin
            status_c = cbfq_pkg::ST_INVALID;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= cbfq_pkg::MODE_OPEN;
         frame_ff     <= '0;
         used_ff      <= '0;
         qbytes_ff    <= '0;
         queued_ff    <= '0;
         rptr_ff      <= '0;
         wptr_ff      <= '0;
         sgen_ff      <= '0;
         sdiag_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            mode_ff   <= mode_in;
            frame_ff  <= frame_in;
            used_ff   <= used_in;
            qbytes_ff <= qbytes_in;
            queued_ff <= queued_in;
            rptr_ff   <= rptr_in;
            wptr_ff   <= wptr_in;
            sgen_ff   <= sgen_in;
            sdiag_ff  <= sdiag_in;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_c;
         oh_ff     <= oh_c;
         ob_ff     <= ob_c;
         og_ff     <= og_c;
         od_ff     <= od_c;
      end
   end

   assign dp_status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {6'b0, used_ff, frame_ff, mode_ff, od_ff, og_ff, ob_ff, oh_ff};

endmodule
